// ===== hw/rtl/kl_plex_check_and_extend_core_assert.svh =====
// Assertion macros for the plex core
`ifndef KL_PLEX_CHECK_AND_EXTEND_CORE_ASSERT_SVH
`define KL_PLEX_CHECK_AND_EXTEND_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define KLPLEX_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("klplex assertion failed");
`define KLPLEX_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("klplex assertion failed");
`else
`define KLPLEX_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define KLPLEX_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== hw/rtl/klplex_pkg.sv =====
`timescale 1ns / 1ps
package klplex_pkg;

	localparam int unsigned KLPLEX_MAX_VERTICES = 64;
	localparam int unsigned KLPLEX_VLIM = 64;

	localparam logic [2:0] MODE_LOAD_OUT = 3'd0;
	localparam logic [2:0] MODE_LOAD_IN = 3'd1;
	localparam logic [2:0] MODE_ADD_SEED = 3'd2;
	localparam logic [2:0] MODE_CLR_SEED = 3'd3;
	localparam logic [2:0] MODE_CHECK = 3'd4;
	localparam logic [2:0] MODE_EXTEND = 3'd5;

	localparam logic [1:0] REG_OUT_SLACK = 2'd0;
	localparam logic [1:0] REG_IN_SLACK = 2'd1;
	localparam logic [1:0] REG_VCOUNT = 2'd2;

	localparam logic [6:0] SLACK_RESET = 7'd2;
	localparam logic [6:0] VCOUNT_RESET = 7'd64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_INIT_END,
		ST_CHK,
		ST_CHK_OUT,
		ST_SCAN_RD,
		ST_SCAN_EV1,
		ST_SCAN_EV2,
		ST_EMIT
	} klplex_state_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  vertex;
		logic [63:0] row_bits;
	} klplex_in_t;

	typedef struct packed {
		logic [5:0] member;
		logic       is_plex;
		logic       last;
	} klplex_out_t;

	typedef struct packed {
		logic       init_we;
		logic       add_we;
		logic       use_row;
		logic [6:0] need;
		logic [5:0] idx;
		logic [6:0] out_deg;
		logic [6:0] in_deg;
	} lane_cmd_t;

	function automatic logic [6:0] pop64(input logic [63:0] x);
		logic [1:0] l1 [32];
		logic [2:0] l2 [16];
		logic [3:0] l3 [8];
		logic [4:0] l4 [4];
		logic [5:0] l5 [2];
		for (int k = 0; k < 32; k++) begin
			l1[k] = {1'b0, x[2*k]} + {1'b0, x[2*k+1]};
		end
		for (int k = 0; k < 16; k++) begin
			l2[k] = {1'b0, l1[2*k]} + {1'b0, l1[2*k+1]};
		end
		for (int k = 0; k < 8; k++) begin
			l3[k] = {1'b0, l2[2*k]} + {1'b0, l2[2*k+1]};
		end
		for (int k = 0; k < 4; k++) begin
			l4[k] = {1'b0, l3[2*k]} + {1'b0, l3[2*k+1]};
		end
		for (int k = 0; k < 2; k++) begin
			l5[k] = {1'b0, l4[2*k]} + {1'b0, l4[2*k+1]};
		end
		return {1'b0, l5[0]} + {1'b0, l5[1]};
	endfunction

endpackage

// ===== hw/rtl/klplex_row_mem.sv =====
`timescale 1ns / 1ps
module klplex_row_mem #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/klplex_deg_lanes.sv =====
`timescale 1ns / 1ps
module klplex_deg_lanes import klplex_pkg::*; #(
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lane_cmd_t        cmd,
	input  logic [DEPTH-1:0] set,
	input  logic [DEPTH-1:0] fr,
	input  logic [DEPTH-1:0] to,
	input  logic [6:0]       out_slack,
	input  logic [6:0]       in_slack,
	output logic             lane_ok
);

	logic [6:0]       out_deg_q [DEPTH];
	logic [6:0]       in_deg_q [DEPTH];
	logic [DEPTH-1:0] ok_vec;
	logic             ok_q;

	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			ok_vec[j] = !set[j] ||
				((9'(out_deg_q[j]) + 9'(cmd.use_row & to[j]) + 9'(out_slack) >= 9'(cmd.need)) &&
				 (9'(in_deg_q[j]) + 9'(cmd.use_row & fr[j]) + 9'(in_slack) >= 9'(cmd.need)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
			for (int j = 0; j < DEPTH; j++) begin
				out_deg_q[j] <= '0;
				in_deg_q[j] <= '0;
			end
		end else begin
			ok_q <= &ok_vec;
			for (int j = 0; j < DEPTH; j++) begin
				if ((cmd.init_we || cmd.add_we) && cmd.idx[AW-1:0] == AW'(j)) begin
					out_deg_q[j] <= cmd.out_deg;
					in_deg_q[j] <= cmd.in_deg;
				end else if (cmd.add_we && set[j]) begin
					out_deg_q[j] <= out_deg_q[j] + 7'(to[j]);
					in_deg_q[j] <= in_deg_q[j] + 7'(fr[j]);
				end
			end
		end
	end

	assign lane_ok = ok_q;

endmodule

// ===== hw/rtl/klplex_ctrl.sv =====
`timescale 1ns / 1ps
`include "kl_plex_check_and_extend_core_assert.svh"
module klplex_ctrl import klplex_pkg::*; #(
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  klplex_in_t       item,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [6:0]       cfg_data,
	output logic             mem_we_out,
	output logic             mem_we_in,
	output logic [AW-1:0]    mem_waddr,
	output logic [DEPTH-1:0] mem_wdata,
	output logic             mem_re,
	output logic [AW-1:0]    mem_raddr,
	input  logic [DEPTH-1:0] out_row,
	input  logic [DEPTH-1:0] in_row,
	output lane_cmd_t        lane_cmd,
	output logic [DEPTH-1:0] fr_m,
	output logic [DEPTH-1:0] to_m,
	output logic [DEPTH-1:0] set,
	output logic [6:0]       out_slack,
	output logic [6:0]       in_slack,
	input  logic             lane_ok,
	output logic             done,
	output klplex_out_t      result
);

	localparam logic [6:0] DEPTH_W = 7'(DEPTH);

	klplex_state_t    state_q, state_d;
	logic [6:0]       cnt_q, emit_q, n_q;
	logic [DEPTH-1:0] set_q, seed_q;
	logic [6:0]       out_slack_q, in_slack_q, vcount_q;
	logic             chk_q, done_q, init_v_s1;
	logic [AW-1:0]    row_idx_s1;
	logic [6:0]       pop_fr_q, pop_to_q;
	klplex_out_t      result_q;

	logic             accept, v_ok, add_ok;
	logic [AW-1:0]    v_idx, cnt_idx;
	logic [6:0]       lim, need_add, pop_fr, pop_to;
	logic [DEPTH-1:0] self_mask;

	assign accept = start && (state_q == ST_IDLE);
	assign v_ok = {1'b0, item.vertex} < DEPTH_W;
	assign v_idx = item.vertex[AW-1:0];
	assign cnt_idx = cnt_q[AW-1:0];
	assign lim = (vcount_q < DEPTH_W) ? vcount_q : DEPTH_W;
	assign need_add = n_q + 7'd1;

	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			self_mask[k] = (AW'(k) != row_idx_s1);
		end
	end

	assign fr_m = out_row & self_mask;
	assign to_m = in_row & self_mask;
	assign pop_fr = pop64(64'(fr_m & set_q));
	assign pop_to = pop64(64'(to_m & set_q));

	assign mem_we_out = accept && (item.mode == MODE_LOAD_OUT) && v_ok;
	assign mem_we_in = accept && (item.mode == MODE_LOAD_IN) && v_ok;
	assign mem_waddr = v_idx;
	assign mem_wdata = item.row_bits[DEPTH-1:0];
	assign mem_raddr = cnt_idx;

	always_comb begin
		state_d = state_q;
		mem_re = 1'b0;
		add_ok = 1'b0;
		lane_cmd = '0;
		lane_cmd.need = n_q;
		if (init_v_s1) begin
			lane_cmd.init_we = 1'b1;
			lane_cmd.idx = 6'(row_idx_s1);
			lane_cmd.out_deg = set_q[row_idx_s1] ? pop_fr : 7'd0;
			lane_cmd.in_deg = set_q[row_idx_s1] ? pop_to : 7'd0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (item.mode == MODE_CHECK || item.mode == MODE_EXTEND)) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				mem_re = 1'b1;
				if (cnt_q == DEPTH_W - 7'd1) begin
					state_d = ST_INIT_END;
				end
			end
			ST_INIT_END: begin
				state_d = chk_q ? ST_CHK : ST_SCAN_RD;
			end
			ST_CHK: begin
				state_d = ST_CHK_OUT;
			end
			ST_CHK_OUT: begin
				state_d = ST_IDLE;
			end
			ST_SCAN_RD: begin
				if (cnt_q >= lim) begin
					state_d = ST_EMIT;
				end else if (!seed_q[cnt_idx]) begin
					mem_re = 1'b1;
					state_d = ST_SCAN_EV1;
				end
			end
			ST_SCAN_EV1: begin
				lane_cmd.use_row = 1'b1;
				lane_cmd.need = need_add;
				state_d = ST_SCAN_EV2;
			end
			ST_SCAN_EV2: begin
				add_ok = lane_ok &&
					(9'(pop_fr_q) + 9'(out_slack_q) >= 9'(need_add)) &&
					(9'(pop_to_q) + 9'(in_slack_q) >= 9'(need_add));
				if (add_ok) begin
					lane_cmd.add_we = 1'b1;
					lane_cmd.idx = 6'(cnt_idx);
					lane_cmd.out_deg = pop_fr_q;
					lane_cmd.in_deg = pop_to_q;
				end
				state_d = ST_SCAN_RD;
			end
			ST_EMIT: begin
				if (n_q == 7'd0 || cnt_q == DEPTH_W - 7'd1 ||
				    (set_q[cnt_idx] && emit_q + 7'd1 == n_q)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			emit_q <= '0;
			n_q <= '0;
			set_q <= '0;
			seed_q <= '0;
			chk_q <= 1'b0;
			done_q <= 1'b0;
			init_v_s1 <= 1'b0;
			out_slack_q <= SLACK_RESET;
			in_slack_q <= SLACK_RESET;
			vcount_q <= VCOUNT_RESET;
		end else begin
			done_q <= 1'b0;
			init_v_s1 <= (state_q == ST_INIT);
			if (cfg_we) begin
				unique case (cfg_index)
					REG_OUT_SLACK: out_slack_q <= cfg_data;
					REG_IN_SLACK:  in_slack_q <= cfg_data;
					REG_VCOUNT:    vcount_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.mode)
							MODE_ADD_SEED: begin
								if (v_ok && !set_q[v_idx]) begin
									set_q[v_idx] <= 1'b1;
									n_q <= n_q + 7'd1;
								end
							end
							MODE_CLR_SEED: begin
								set_q <= '0;
								n_q <= '0;
							end
							MODE_CHECK: begin
								chk_q <= 1'b1;
								cnt_q <= '0;
							end
							MODE_EXTEND: begin
								chk_q <= 1'b0;
								cnt_q <= '0;
								seed_q <= set_q;
							end
							default: ;
						endcase
					end
				end
				ST_INIT: begin
					cnt_q <= (cnt_q == DEPTH_W - 7'd1) ? 7'd0 : cnt_q + 7'd1;
				end
				ST_CHK_OUT: begin
					done_q <= 1'b1;
				end
				ST_SCAN_RD: begin
					if (cnt_q >= lim) begin
						cnt_q <= '0;
						emit_q <= '0;
					end else if (seed_q[cnt_idx]) begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_SCAN_EV2: begin
					if (add_ok) begin
						set_q[cnt_idx] <= 1'b1;
						n_q <= need_add;
					end
					cnt_q <= cnt_q + 7'd1;
				end
				ST_EMIT: begin
					if (n_q != 7'd0 && set_q[cnt_idx]) begin
						done_q <= 1'b1;
						emit_q <= emit_q + 7'd1;
					end
					cnt_q <= cnt_q + 7'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			row_idx_s1 <= mem_raddr;
		end
		if (state_q == ST_SCAN_EV1) begin
			pop_fr_q <= pop_fr;
			pop_to_q <= pop_to;
		end
		if (state_q == ST_CHK_OUT) begin
			result_q.member <= '0;
			result_q.is_plex <= lane_ok;
			result_q.last <= 1'b1;
		end else if (state_q == ST_EMIT) begin
			result_q.member <= 6'(cnt_idx);
			result_q.is_plex <= 1'b1;
			result_q.last <= (emit_q + 7'd1 == n_q);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign set = set_q;
	assign out_slack = out_slack_q;
	assign in_slack = in_slack_q;
	assign done = done_q;
	assign result = result_q;

	`KLPLEX_ASSERT_IMP(a_count_tracks_set, clk, arst_n, 1'b1, n_q == pop64(64'(set_q)))
	`KLPLEX_ASSERT_IMP(a_scan_skips_seed, clk, arst_n, state_q == ST_SCAN_EV1, !seed_q[cnt_idx] && cnt_q < lim)
	`KLPLEX_ASSERT_IMP(a_seed_kept, clk, arst_n, state_q == ST_SCAN_RD, (set_q & seed_q) == seed_q)
	`KLPLEX_ASSERT_NEXT(a_scan_set_grows, clk, arst_n, state_q == ST_SCAN_EV2, (set_q & $past(set_q)) == $past(set_q))

endmodule

// ===== hw/rtl/kl_plex_check_and_extend_core.sv =====
`timescale 1ns / 1ps
// Directed (K,L)-plex check and greedy extension core.
// Commands enter on item when start is high and busy is low. Modes: load
// out-row, load in-row, add seed vertex, clear seed, check, extend. Loads and
// seed edits are done while the core stays idle and return no transaction.
// Results leave on result, each valid for exactly one cycle while done is high;
// the receiver cannot hold them off. Check returns one transaction on the ports
// after rebuilding the degree lanes over DEPTH = min(MAX_VERTICES, 64) rows.
// Extend rebuilds the degree lanes from the row memories (one row pair per
// cycle), then scans the vertices below min(vertex_count, DEPTH), skipping seed
// vertices and taking each candidate through a row read, a lane compare and a
// decide-and-update step, then walks the vertex indices up to the last member
// and streams the set in ascending order with last on the final transaction.
// The candidate loop is set by the single read port of each row memory and the
// dependence of each decision on the set left by the previous one.
// Configuration writes (cfg_we, cfg_index, cfg_data) apply from the next cycle.
// Reset clears the member set, the degree lanes and the control state and
// restores K = L = 2 and vertex_count = 64; row memories are not cleared.
module kl_plex_check_and_extend_core import klplex_pkg::*; #(
	parameter int unsigned MAX_VERTICES = KLPLEX_MAX_VERTICES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  klplex_in_t  item,
	output logic        done,
	output klplex_out_t result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	localparam int unsigned DEPTH = (MAX_VERTICES < KLPLEX_VLIM) ? MAX_VERTICES : KLPLEX_VLIM;
	localparam int unsigned AW = $clog2(DEPTH);

	logic             mem_we_out, mem_we_in, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [DEPTH-1:0] mem_wdata, out_row, in_row;
	logic [DEPTH-1:0] fr_m, to_m, set;
	logic [6:0]       out_slack, in_slack;
	logic             lane_ok;
	lane_cmd_t        lane_cmd;

	klplex_row_mem #(.WIDTH(DEPTH), .DEPTH(DEPTH)) u_out_rows (
		.clk   (clk),
		.we    (mem_we_out),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (out_row)
	);

	klplex_row_mem #(.WIDTH(DEPTH), .DEPTH(DEPTH)) u_in_rows (
		.clk   (clk),
		.we    (mem_we_in),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (in_row)
	);

	klplex_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mem_we_out (mem_we_out),
		.mem_we_in  (mem_we_in),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.out_row    (out_row),
		.in_row     (in_row),
		.lane_cmd   (lane_cmd),
		.fr_m       (fr_m),
		.to_m       (to_m),
		.set        (set),
		.out_slack  (out_slack),
		.in_slack   (in_slack),
		.lane_ok    (lane_ok),
		.done       (done),
		.result     (result)
	);

	klplex_deg_lanes #(.DEPTH(DEPTH)) u_lanes (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (lane_cmd),
		.set       (set),
		.fr        (fr_m),
		.to        (to_m),
		.out_slack (out_slack),
		.in_slack  (in_slack),
		.lane_ok   (lane_ok)
	);

endmodule

// ===== tb/klplex_result_checker.sv =====
`timescale 1ns / 1ps
module klplex_result_checker import klplex_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  klplex_in_t  item,
	input  logic        done,
	input  klplex_out_t result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	output int          fail_count,
	output int          pending
);

	logic [63:0] out_rows [64];
	logic [63:0] in_rows [64];
	logic [63:0] members;
	logic [6:0]  k_slack;
	logic [6:0]  l_slack;
	logic [6:0]  scan_count;
	int          mismatches;
	klplex_out_t expected_members [$];

	function automatic logic [63:0] out_nbrs(input int v);
		return out_rows[v] & ~(64'd1 << v);
	endfunction

	function automatic logic [63:0] in_nbrs(input int v);
		return in_rows[v] & ~(64'd1 << v);
	endfunction

	function automatic logic plex_holds(input logic [63:0] s);
		int n;
		n = $countones(s);
		for (int x = 0; x < 64; x++) begin
			if (s[x]) begin
				if ($countones(out_nbrs(x) & s) + k_slack < n)
					return 1'b0;
				if ($countones(in_nbrs(x) & s) + l_slack < n)
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic logic [63:0] greedy_grow(input logic [63:0] seed);
		logic [63:0] s;
		logic [63:0] fr;
		logic [63:0] to;
		logic        ok;
		int          n;
		int          lim;
		int          out_deg [64];
		int          in_deg [64];
		s = seed;
		n = $countones(s);
		lim = (scan_count > 64) ? 64 : int'(scan_count);
		for (int j = 0; j < 64; j++) begin
			out_deg[j] = s[j] ? $countones(out_nbrs(j) & s) : 0;
			in_deg[j] = s[j] ? $countones(in_nbrs(j) & s) : 0;
		end
		for (int i = 0; i < lim; i++) begin
			if (!seed[i]) begin
				fr = out_nbrs(i);
				to = in_nbrs(i);
				ok = ($countones(fr & s) + k_slack >= n + 1) &&
					($countones(to & s) + l_slack >= n + 1);
				for (int j = 0; j < 64; j++) begin
					if (ok && s[j]) begin
						if (out_deg[j] + to[j] + k_slack < n + 1)
							ok = 1'b0;
						if (in_deg[j] + fr[j] + l_slack < n + 1)
							ok = 1'b0;
					end
				end
				if (ok) begin
					for (int j = 0; j < 64; j++) begin
						if (s[j]) begin
							out_deg[j] += to[j];
							in_deg[j] += fr[j];
						end
					end
					out_deg[i] = $countones(fr & s);
					in_deg[i] = $countones(to & s);
					s[i] = 1'b1;
					n++;
				end
			end
		end
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		klplex_out_t want;
		int          total;
		int          cnt;
		if (!arst_n) begin
			members = '0;
			k_slack = SLACK_RESET;
			l_slack = SLACK_RESET;
			scan_count = VCOUNT_RESET;
			mismatches = 0;
			expected_members.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_members.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %p", $time, result);
					mismatches++;
				end else begin
					want = expected_members.pop_front();
					if (result.member !== want.member) begin
						$display("%0t: member mismatch: expected %0d, actual %0d",
							$time, want.member, result.member);
						mismatches++;
					end
					if (result.is_plex !== want.is_plex) begin
						$display("%0t: is_plex mismatch: expected %0b, actual %0b",
							$time, want.is_plex, result.is_plex);
						mismatches++;
					end
					if (result.last !== want.last) begin
						$display("%0t: last mismatch: expected %0b, actual %0b",
							$time, want.last, result.last);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_OUT_SLACK: k_slack = cfg_data;
					REG_IN_SLACK: l_slack = cfg_data;
					REG_VCOUNT: scan_count = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (item.mode)
					MODE_LOAD_OUT: out_rows[item.vertex] = item.row_bits;
					MODE_LOAD_IN: in_rows[item.vertex] = item.row_bits;
					MODE_ADD_SEED: members[item.vertex] = 1'b1;
					MODE_CLR_SEED: members = '0;
					MODE_CHECK: begin
						want.member = '0;
						want.is_plex = plex_holds(members);
						want.last = 1'b1;
						expected_members = {expected_members, want};
					end
					MODE_EXTEND: begin
						members = greedy_grow(members);
						total = $countones(members);
						cnt = 0;
						for (int x = 0; x < 64; x++) begin
							if (members[x]) begin
								cnt++;
								want.member = 6'(x);
								want.is_plex = 1'b1;
								want.last = (cnt == total);
								expected_members = {expected_members, want};
							end
						end
					end
					default: ;
				endcase
			end
			fail_count <= mismatches;
			pending <= expected_members.size();
		end
	end

endmodule

// ===== tb/tb_kl_plex_check_and_extend_core.sv =====
`timescale 1ns / 1ps
module tb_kl_plex_check_and_extend_core;
	import klplex_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_ITEMS = 50;
	localparam int PHASE_ITEMS = 15;
	localparam logic [2:0] MODE_RSVD_LO = 3'd6;
	localparam logic [2:0] MODE_RSVD_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	klplex_in_t  item;
	logic        done;
	klplex_out_t result;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [6:0]  cfg_data;
	int          fail_count;
	int          pending;
	int          cycle_count = 0;
	int          sent = 0;
	logic        gaps_on = 1'b1;

	kl_plex_check_and_extend_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	klplex_result_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_kl_plex_check_and_extend_core: done, errors");
			$finish;
		end
	end

	function automatic logic [63:0] random_row(input int density);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case (density)
			0: return a & b;
			1: return a;
			2: return a | b;
			default: return a | b | c;
		endcase
	endfunction

	task automatic issue(input logic [2:0] mode, input logic [5:0] v, input logic [63:0] row);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= {mode, v, row};
		do @(posedge clk); while (busy);
		if (mode <= MODE_EXTEND)
			sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [6:0] k, input logic [6:0] l, input logic [6:0] vc);
		write_reg(REG_OUT_SLACK, k);
		write_reg(REG_IN_SLACK, l);
		write_reg(REG_VCOUNT, vc);
	endtask

	task automatic load_graph(input int density);
		logic [63:0] adj [64];
		logic [63:0] col;
		for (int v = 0; v < 64; v++)
			adj[v] = random_row(density);
		for (int v = 0; v < 64; v++)
			issue(MODE_LOAD_OUT, 6'(v), adj[v]);
		for (int v = 0; v < 64; v++) begin
			for (int y = 0; y < 64; y++)
				col[y] = adj[y][v];
			if ($urandom_range(0, 7) == 0)
				col = random_row(density);
			issue(MODE_LOAD_IN, 6'(v), col);
		end
	endtask

	task automatic random_sequence();
		int r;
		int seeds;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			issue(MODE_CLR_SEED, 6'($urandom), random_row(1));
			seeds = $urandom_range(0, 4);
			repeat (seeds) issue(MODE_ADD_SEED, 6'($urandom), random_row(1));
			issue(MODE_CHECK, 6'($urandom), random_row(1));
			issue(MODE_EXTEND, 6'($urandom), random_row(1));
			if ($urandom_range(0, 1))
				issue(MODE_CHECK, 6'($urandom), random_row(1));
		end else if (r < 9) begin
			issue($urandom_range(0, 1) ? MODE_LOAD_OUT : MODE_LOAD_IN, 6'($urandom),
				random_row($urandom_range(0, 3)));
		end else begin
			issue(3'($urandom_range(0, 7)), 6'($urandom), random_row(1));
		end
	endtask

	initial begin
		int phase;
		int random_base;
		int phase_end;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (busy);

		load_graph(2);

		issue(MODE_CHECK, 6'd0, '0);
		issue(MODE_EXTEND, 6'd63, '1);
		issue(MODE_CHECK, 6'd0, '0);
		issue(MODE_LOAD_OUT, 6'd0, '0);
		issue(MODE_LOAD_IN, 6'd0, '0);
		issue(MODE_LOAD_OUT, 6'd1, '1);
		issue(MODE_LOAD_IN, 6'd1, '1);
		issue(MODE_CLR_SEED, 6'd63, '1);
		issue(MODE_ADD_SEED, 6'd0, '0);
		issue(MODE_ADD_SEED, 6'd1, '1);
		issue(MODE_ADD_SEED, 6'd1, '0);
		settle();
		configure(7'd1, 7'd1, 7'd64);
		issue(MODE_CHECK, 6'd0, '0);
		issue(MODE_EXTEND, 6'd0, '0);
		issue(MODE_RSVD_LO, 6'd5, random_row(1));
		issue(MODE_RSVD_HI, 6'd63, '1);
		settle();
		configure(7'd64, 7'd64, 7'd0);
		issue(MODE_CLR_SEED, 6'd0, '0);
		issue(MODE_EXTEND, 6'd0, '0);
		issue(MODE_ADD_SEED, 6'd63, '0);
		issue(MODE_EXTEND, 6'd0, '0);
		settle();
		configure(7'd64, 7'd64, 7'd100);
		issue(MODE_CLR_SEED, 6'd0, '0);
		issue(MODE_EXTEND, 6'd0, '0);
		issue(MODE_CHECK, 6'd0, '0);

		random_base = sent;
		phase = 0;
		while (sent - random_base < RANDOM_ITEMS) begin
			settle();
			case (phase)
				0: configure(7'd1, 7'd1, 7'd64);
				1: configure(7'd64, 7'd64, 7'd27);
				2: configure(7'd2, 7'd3, 7'd64);
				3: configure(7'd31, 7'd24, 7'd48);
				default: configure(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
					7'($urandom_range(1, 64)));
			endcase
			gaps_on = (phase != 2);
			phase_end = sent + PHASE_ITEMS;
			while (sent < phase_end && sent - random_base < RANDOM_ITEMS) begin
				if (sent - random_base >= RANDOM_ITEMS - PHASE_ITEMS)
					gaps_on = 1'b0;
				random_sequence();
			end
			phase++;
		end

		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (80) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_kl_plex_check_and_extend_core: done, clean");
		end else begin
			$display("tb_kl_plex_check_and_extend_core: done, errors");
		end
		$finish;
	end

endmodule

// ===== kl_plex_check_and_extend_core.f =====
+incdir+hw/rtl
hw/rtl/klplex_pkg.sv
hw/rtl/klplex_row_mem.sv
hw/rtl/klplex_deg_lanes.sv
hw/rtl/klplex_ctrl.sv
hw/rtl/kl_plex_check_and_extend_core.sv
tb/klplex_result_checker.sv
tb/tb_kl_plex_check_and_extend_core.sv
